/* rtl/core/flcp_pkg.sv */
// ----------------------------------------------------------------------------
// flcp_pkg: shared types and constants for the free-look camera pose block
// Payload structs, fixed-point limits and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package flcp_pkg;

	localparam logic [1:0] KIND_ADD_ROT = 2'd0;
	localparam logic [1:0] KIND_SET_ROT = 2'd1;
	localparam logic [1:0] KIND_ADD_POS = 2'd2;
	localparam logic [1:0] KIND_SET_POS = 2'd3;

	localparam int TWO_PI_Q12  = 25736;
	localparam int HALF_PI_Q12 = 6434;
	localparam int ONE_Q14     = 16384;
	localparam int TABLE_LEN   = 24;

	typedef struct packed {
		logic [1:0]         kind;
		logic signed [15:0] yaw_value;
		logic signed [15:0] pitch_value;
		logic signed [31:0] move_x;
		logic signed [31:0] move_y;
		logic signed [31:0] move_z;
	} cmd_t;

	typedef struct packed {
		logic signed [15:0] right_x;
		logic signed [15:0] right_y;
		logic signed [15:0] right_z;
		logic signed [15:0] up_x;
		logic signed [15:0] up_y;
		logic signed [15:0] up_z;
		logic signed [15:0] forward_x;
		logic signed [15:0] forward_y;
		logic signed [15:0] forward_z;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
	} res_t;

	typedef struct packed {
		logic               done;
		logic signed [15:0] sin_v;
		logic signed [15:0] cos_v;
	} sincos_t;

	// arctan(2^-i) in Q2.30, truncated
	function automatic logic [31:0] atan_q30(input logic [4:0] idx);
		logic [31:0] r;
		case (idx)
			5'd0:  r = 32'd843314856;
			5'd1:  r = 32'd497837829;
			5'd2:  r = 32'd263043836;
			5'd3:  r = 32'd133525158;
			5'd4:  r = 32'd67021686;
			5'd5:  r = 32'd33543515;
			5'd6:  r = 32'd16775850;
			5'd7:  r = 32'd8388437;
			5'd8:  r = 32'd4194282;
			5'd9:  r = 32'd2097149;
			5'd10: r = 32'd1048575;
			5'd11: r = 32'd524287;
			5'd12: r = 32'd262143;
			5'd13: r = 32'd131071;
			5'd14: r = 32'd65535;
			5'd15: r = 32'd32767;
			5'd16: r = 32'd16383;
			5'd17: r = 32'd8191;
			5'd18: r = 32'd4095;
			5'd19: r = 32'd2047;
			5'd20: r = 32'd1023;
			5'd21: r = 32'd511;
			5'd22: r = 32'd255;
			5'd23: r = 32'd127;
			default: r = 32'd0;
		endcase
		return r;
	endfunction

endpackage

/* rtl/core/flcp_cordic.sv */
// ----------------------------------------------------------------------------
// flcp_cordic: iterative rotation-mode CORDIC
// One micro-rotation per cycle; returns sine and cosine rounded to Q1.14.
// ----------------------------------------------------------------------------
module flcp_cordic #(
	parameter int STEPS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic signed [15:0]   angle,
	output flcp_pkg::sincos_t    result
);
	import flcp_pkg::*;

	localparam int NSTEP = (STEPS > TABLE_LEN) ? TABLE_LEN : STEPS;
	localparam logic signed [35:0] HALF_PI_Q30 = 36'sd1686629713;
	localparam logic signed [35:0] PI_Q30      = 36'sd3373259426;
	localparam logic signed [33:0] X0          = 34'sd652032874;

	logic               busy_q;
	logic               done_q;
	logic [4:0]         cnt_q;
	logic               flip_q;
	logic signed [33:0] x_q, y_q;
	logic signed [35:0] z_q;
	logic signed [15:0] sin_q, cos_q;

	logic signed [35:0] z0, z1, z2;
	logic               f1, f2;
	logic signed [33:0] dx, dy, xf, yf;
	logic signed [17:0] xr, yr;

	always_comb begin
		z0 = {{2{angle[15]}}, angle, 18'd0};
		f1 = z0 > HALF_PI_Q30;
		z1 = f1 ? z0 - PI_Q30 : z0;
		f2 = z1 > HALF_PI_Q30;
		z2 = f2 ? z1 - PI_Q30 : z1;
		dx = y_q >>> cnt_q;
		dy = x_q >>> cnt_q;
		xf = flip_q ? -x_q : x_q;
		yf = flip_q ? -y_q : y_q;
		xr = 18'((xf + 34'sd32768) >>> 16);
		yr = 18'((yf + 34'sd32768) >>> 16);
	end

	function automatic logic signed [15:0] clamp14(input logic signed [17:0] v);
		logic signed [15:0] r;
		if (v > 18'sd16384)       r = 16'sd16384;
		else if (v < -18'sd16384) r = -16'sd16384;
		else                      r = v[15:0];
		return r;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= !start && busy_q && (cnt_q == 5'(NSTEP - 1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == 5'(NSTEP - 1)) begin
					busy_q <= 1'b0;
				end
				cnt_q <= cnt_q + 5'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q    <= X0;
			y_q    <= '0;
			z_q    <= z2;
			flip_q <= f1 ^ f2;
		end else if (busy_q) begin
			if (!z_q[35]) begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - $signed({4'd0, atan_q30(cnt_q)});
			end else begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + $signed({4'd0, atan_q30(cnt_q)});
			end
		end
		if (done_q) begin
			cos_q <= clamp14(xr);
			sin_q <= clamp14(yr);
		end
	end

	// outputs are registered while done_q is high, so they appear in the cycle after it; delay the flag to match
	logic done_d_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done_d_q <= 1'b0;
		else         done_d_q <= done_q;
	end

	assign result.done  = done_d_q;
	assign result.sin_v = sin_q;
	assign result.cos_v = cos_q;

endmodule

/* rtl/core/free_look_camera_pose.sv */
// ----------------------------------------------------------------------------
// free_look_camera_pose: yaw/pitch camera with an orthonormal basis
// Keeps yaw, pitch, position and basis; returns basis and position per beat.
// ----------------------------------------------------------------------------
// One command beat is taken at a time. A rotation beat runs the CORDIC twice
// (yaw, then pitch), then four basis products on the shared multiplier. An
// add-position beat runs nine products on it; a set-position beat goes
// straight to the result. After reset the block builds the identity basis
// before it takes the first beat. The result register lets the next beat
// enter while a result is still waiting.
module free_look_camera_pose #(
	parameter int CORDIC_STEPS = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cmd_valid,
	output logic             cmd_stall,
	input  flcp_pkg::cmd_t   cmd,
	output logic             res_valid,
	input  logic             res_stall,
	output flcp_pkg::res_t   res
);
	import flcp_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_SCY  = 3'd1;
	localparam logic [2:0] ST_WCY  = 3'd2;
	localparam logic [2:0] ST_SCP  = 3'd3;
	localparam logic [2:0] ST_WCP  = 3'd4;
	localparam logic [2:0] ST_BMUL = 3'd5;
	localparam logic [2:0] ST_PMUL = 3'd6;
	localparam logic [2:0] ST_DONE = 3'd7;

	logic [2:0]         state_q;
	logic               init_q;
	logic               ph_q;
	logic [1:0]         k_q, j_q;
	logic [14:0]        yaw_q;
	logic signed [13:0] pitch_q;
	logic signed [31:0] pos_q [3];
	logic signed [31:0] mx_q, my_q, mz_q;
	logic signed [15:0] sy_q, cy_q, sp_q, cp_q;
	logic signed [15:0] b3_q, b5_q, b6_q, b8_q;
	logic signed [47:0] prod_q;
	logic signed [49:0] acc_q;
	logic               res_valid_q;
	res_t               res_q;

	sincos_t            cs;
	logic               cs_start;
	logic signed [15:0] cs_angle;

	assign cs_start = (state_q == ST_SCY) || (state_q == ST_SCP);
	assign cs_angle = (state_q == ST_SCY) ? {1'b0, yaw_q} : 16'(pitch_q);

	flcp_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cs_start),
		.angle  (cs_angle),
		.result (cs)
	);

	// angle update for an accepted rotation beat
	logic signed [16:0] yv;
	logic signed [17:0] ysum;
	logic signed [16:0] psum;
	logic [14:0]        yaw_n;
	logic signed [13:0] pitch_n;
	always_comb begin
		if (cmd.yaw_value > 16'sd25736)       yv = 17'sd25736;
		else if (cmd.yaw_value < -16'sd25736) yv = -17'sd25736;
		else                                  yv = 17'(cmd.yaw_value);
		ysum = (cmd.kind == KIND_ADD_ROT) ? $signed({3'd0, yaw_q}) + 18'(yv) : 18'(yv);
		psum = (cmd.kind == KIND_ADD_ROT) ? 17'(pitch_q) + 17'(cmd.pitch_value)
		                                  : 17'(cmd.pitch_value);
		if (ysum > 18'sd25736)   yaw_n = 15'(ysum - 18'sd25736);
		else if (ysum < 18'sd0)  yaw_n = 15'(ysum + 18'sd25736);
		else                     yaw_n = 15'(ysum);
		if (psum > 17'sd6434)       pitch_n = 14'sd6434;
		else if (psum < -17'sd6434) pitch_n = -14'sd6434;
		else                        pitch_n = 14'(psum);
	end

	// shared multiplier operand select
	logic signed [31:0] ma;
	logic signed [15:0] mb;
	always_comb begin
		ma = '0;
		mb = '0;
		if (state_q == ST_BMUL) begin
			case (k_q)
				2'd0: begin ma = 32'(sy_q); mb = sp_q; end
				2'd1: begin ma = 32'(sp_q); mb = cy_q; end
				2'd2: begin ma = 32'(sy_q); mb = cp_q; end
				default: begin ma = 32'(cp_q); mb = cy_q; end
			endcase
		end else begin
			case (j_q)
				2'd0: ma = mx_q;
				2'd1: ma = my_q;
				default: ma = mz_q;
			endcase
			case ({k_q, j_q})
				4'h0: mb = cy_q;
				4'h1: mb = b3_q;
				4'h2: mb = b6_q;
				4'h4: mb = 16'sd0;
				4'h5: mb = cp_q;
				4'h6: mb = sp_q;
				4'h8: mb = sy_q;
				4'h9: mb = b5_q;
				4'hA: mb = b8_q;
				default: mb = 16'sd0;
			endcase
		end
	end

	logic signed [47:0] r14_full;
	logic signed [15:0] r14;
	logic signed [49:0] acc_n;
	logic signed [35:0] rnd;
	logic signed [36:0] psat_sum;
	logic signed [31:0] psat;
	always_comb begin
		r14_full = (prod_q + 48'sd8192) >>> 14;
		r14      = r14_full[15:0];
		acc_n    = ((j_q == 2'd0) ? 50'sd0 : acc_q) + 50'(prod_q);
		rnd      = 36'((acc_n + 50'sd8192) >>> 14);
		psat_sum = 37'(pos_q[k_q]) + 37'(rnd);
		if (psat_sum > 37'sd2147483647)       psat = 32'sh7FFFFFFF;
		else if (psat_sum < -37'sd2147483648) psat = 32'sh80000000;
		else                                  psat = psat_sum[31:0];
	end

	logic res_free;
	assign res_free  = !res_valid_q || !res_stall;
	assign cmd_stall = (state_q != ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_SCY;
			init_q      <= 1'b1;
			ph_q        <= 1'b0;
			k_q         <= '0;
			j_q         <= '0;
			yaw_q       <= '0;
			pitch_q     <= '0;
			pos_q[0]    <= '0;
			pos_q[1]    <= '0;
			pos_q[2]    <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_DONE && res_free) res_valid_q <= 1'b1;
			else if (!res_stall)                res_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (cmd_valid) begin
						ph_q <= 1'b0;
						k_q  <= '0;
						j_q  <= '0;
						case (cmd.kind)
							KIND_ADD_ROT, KIND_SET_ROT: begin
								yaw_q   <= yaw_n;
								pitch_q <= pitch_n;
								state_q <= ST_SCY;
							end
							KIND_ADD_POS: state_q <= ST_PMUL;
							default: begin
								pos_q[0] <= cmd.move_x;
								pos_q[1] <= cmd.move_y;
								pos_q[2] <= cmd.move_z;
								state_q  <= ST_DONE;
							end
						endcase
					end
				end
				ST_SCY: state_q <= ST_WCY;
				ST_WCY: if (cs.done) state_q <= ST_SCP;
				ST_SCP: state_q <= ST_WCP;
				ST_WCP: if (cs.done) state_q <= ST_BMUL;
				ST_BMUL: begin
					ph_q <= !ph_q;
					if (ph_q) begin
						// wraps back to zero after the last product
						k_q <= k_q + 2'd1;
						if (k_q == 2'd3) begin
							state_q <= init_q ? ST_IDLE : ST_DONE;
							init_q  <= 1'b0;
						end
					end
				end
				ST_PMUL: begin
					ph_q <= !ph_q;
					if (ph_q) begin
						if (j_q == 2'd2) begin
							pos_q[k_q] <= psat;
							j_q        <= '0;
							k_q        <= (k_q == 2'd2) ? 2'd0 : k_q + 2'd1;
							if (k_q == 2'd2) state_q <= ST_DONE;
						end else begin
							j_q <= j_q + 2'd1;
						end
					end
				end
				default: begin
					// hold until the result register can take the beat
					if (res_free) begin
						state_q <= ST_IDLE;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && cmd_valid) begin
			mx_q <= cmd.move_x;
			my_q <= cmd.move_y;
			mz_q <= cmd.move_z;
		end
		if (state_q == ST_WCY && cs.done) begin
			sy_q <= cs.sin_v;
			cy_q <= cs.cos_v;
		end
		if (state_q == ST_WCP && cs.done) begin
			sp_q <= cs.sin_v;
			cp_q <= cs.cos_v;
		end
		if (!ph_q) prod_q <= ma * mb;
		if (state_q == ST_BMUL && ph_q) begin
			case (k_q)
				2'd0: b3_q <= r14;
				2'd1: b5_q <= -r14;
				2'd2: b6_q <= -r14;
				default: b8_q <= r14;
			endcase
		end
		if (state_q == ST_PMUL && ph_q) acc_q <= acc_n;
		if (state_q == ST_DONE && res_free) begin
			res_q.right_x   <= cy_q;
			res_q.right_y   <= '0;
			res_q.right_z   <= sy_q;
			res_q.up_x      <= b3_q;
			res_q.up_y      <= cp_q;
			res_q.up_z      <= b5_q;
			res_q.forward_x <= -b6_q;
			res_q.forward_y <= -sp_q;
			res_q.forward_z <= -b8_q;
			res_q.pos_x     <= pos_q[0];
			res_q.pos_y     <= pos_q[1];
			res_q.pos_z     <= pos_q[2];
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule
